### rtl/ogrf_pkg.sv
// ----------------------------------------------------------------------------
// ogrf_pkg: shared definitions for the occupancy grid rectangle fill block
// Grid limits, operation and cell codes, register indexes, and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ogrf_pkg;

  // Grid storage limits.
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Fixed field widths.
  localparam int FUNC_W  = 2;
  localparam int COORD_W = 6;
  localparam int CELL_W  = 2;
  localparam int SIZE_W  = 7;
  localparam int CFG_IW  = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Cell answers of a read.
  localparam logic [CELL_W-1:0] CELL_FREE     = 2'd0;
  localparam logic [CELL_W-1:0] CELL_OBSTACLE = 2'd1;
  localparam logic [CELL_W-1:0] CELL_STATION  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_ROWS    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_COLS    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_STN_ROW = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_STN_COL = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted request
    logic clear;      // empty the grid
    logic rd_issue;   // read the row of a single-cell read
    logic mark_step;  // read the next rectangle row and advance
    logic load_out;   // capture the result into the output register
  } ogrf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;   // request is a clear
    logic mark_go;    // in-range, non-empty rectangle
    logic read_go;    // in-range read
    logic last_row;   // row counter is at the last rectangle row
  } ogrf_stat_t;

endpackage

### rtl/ogrf_ctrl.sv
// ----------------------------------------------------------------------------
// ogrf_ctrl: operation sequencer
// Accepts one request at a time, steps the datapath through clear, read or
// a row-by-row rectangle fill, and owns the output valid flag.
// ----------------------------------------------------------------------------
module ogrf_ctrl
  import ogrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ogrf_stat_t stat,
  output ogrf_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_MARK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.mark_go) begin
          state_nxt = ST_MARK;
        end else begin
          cmd.clear    = stat.is_clear;
          cmd.rd_issue = stat.read_go;
          state_nxt    = ST_DONE;
        end
      end
      ST_MARK: begin
        cmd.mark_step = 1'b1;
        if (stat.last_row) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last row write completes in this cycle.
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag: set on a new result, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("result loaded while output register was occupied");

  // The fill sequence always ends in the drain state before the result.
  a_drain_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) && stat.last_row |=> (state_r == ST_DRAIN) && !in_ready)
    else $error("rectangle fill did not drain its last row");

  // Only a mark request enters the fill sequence.
  a_mark_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) && !stat.mark_go |=> (state_r == ST_DONE))
    else $error("non-fill request entered the fill sequence");

endmodule

### rtl/ogrf_dp.sv
// ----------------------------------------------------------------------------
// ogrf_dp: grid datapath
// Holds the configuration registers, the request fields, the row memory with
// its per-row valid bits, the row counter, the read-modify-write stage of the
// rectangle fill and the result register.
// ----------------------------------------------------------------------------
module ogrf_dp
  import ogrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Configuration write port.
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]  cfg_wdata,
  // Request fields.
  input  logic [FUNC_W-1:0]  func,
  input  logic [COORD_W-1:0] row_low,
  input  logic [COORD_W-1:0] col_low,
  input  logic [COORD_W-1:0] row_high,
  input  logic [COORD_W-1:0] col_high,
  // Result fields.
  output logic [CELL_W-1:0]  cell_state,
  output logic               station_refused,
  output logic               out_of_range,
  // Controller link.
  input  ogrf_cmd_t          cmd,
  output ogrf_stat_t         stat
);

  // Configuration registers.
  logic [SIZE_W-1:0]  rows_r, cols_r;
  logic [COORD_W-1:0] stn_row_r, stn_col_r;

  // Captured request.
  logic [FUNC_W-1:0]  func_r;
  logic [COORD_W-1:0] rlo_r, clo_r, rhi_r, chi_r;

  // Row memory, valid bits and fill pipeline.
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data_r;
  logic [MAX_ROWS-1:0] valid_r;
  logic [ROW_AW-1:0]   row_r;
  logic [ROW_AW-1:0]   wr_row_r;
  logic                wr_pend_r;

  // Result register.
  logic [CELL_W-1:0] cell_r;
  logic              refused_r, oor_r;

  logic [ROW_AW-1:0]   rd_addr;
  logic                rd_en;
  logic [MAX_COLS-1:0] wr_mask;
  logic [MAX_COLS-1:0] wr_data;
  logic                wr_row_is_stn;
  logic                rlo_ok, rhi_ok, clo_ok, chi_ok;
  logic                nonempty, stn_hit, stn_at_read;
  logic                mark_oor, read_oor, mark_go, read_go;
  logic [CELL_W-1:0]   cell_nxt;
  logic                refused_nxt, oor_nxt;
  logic                stored_bit;

  // Configuration writes; unused indexes leave everything unchanged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= SIZE_W'(64);
      cols_r    <= SIZE_W'(64);
      stn_row_r <= '0;
      stn_col_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS:    rows_r    <= cfg_wdata;
        CFG_COLS:    cols_r    <= cfg_wdata;
        CFG_STN_ROW: stn_row_r <= cfg_wdata[COORD_W-1:0];
        CFG_STN_COL: stn_col_r <= cfg_wdata[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      rlo_r  <= row_low;
      clo_r  <= col_low;
      rhi_r  <= row_high;
      chi_r  <= col_high;
    end
  end

  // Range checks against the configured size, capped by the storage size.
  assign rlo_ok = ({1'b0, rlo_r} < rows_r) && (int'(rlo_r) < MAX_ROWS);
  assign rhi_ok = ({1'b0, rhi_r} < rows_r) && (int'(rhi_r) < MAX_ROWS);
  assign clo_ok = ({1'b0, clo_r} < cols_r) && (int'(clo_r) < MAX_COLS);
  assign chi_ok = ({1'b0, chi_r} < cols_r) && (int'(chi_r) < MAX_COLS);

  assign mark_oor = !(rlo_ok && rhi_ok && clo_ok && chi_ok);
  assign read_oor = !(rlo_ok && clo_ok);
  assign nonempty = (rlo_r <= rhi_r) && (clo_r <= chi_r);
  assign mark_go  = (func_r == FUNC_MARK) && !mark_oor && nonempty;
  assign read_go  = (func_r == FUNC_READ) && !read_oor;

  // The station lies inside the rectangle.
  assign stn_hit = (stn_row_r >= rlo_r) && (stn_row_r <= rhi_r) &&
                   (stn_col_r >= clo_r) && (stn_col_r <= chi_r);
  assign stn_at_read = (rlo_r == stn_row_r) && (clo_r == stn_col_r);

  assign stat.is_clear = (func_r == FUNC_CLEAR);
  assign stat.mark_go  = mark_go;
  assign stat.read_go  = read_go;
  assign stat.last_row = (int'(row_r) == int'(rhi_r));

  // Row counter of the fill.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= ROW_AW'(row_low);
    end else if (cmd.mark_step) begin
      row_r <= row_r + 1'b1;
    end
  end

  // Memory read port: the fill row, or the row of a single-cell read.
  assign rd_en   = cmd.mark_step || cmd.rd_issue;
  assign rd_addr = cmd.mark_step ? row_r : ROW_AW'(rlo_r);

  // Column mask of the row being written, with the station bit held back.
  assign wr_row_is_stn = (int'(wr_row_r) == int'(stn_row_r));
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      wr_mask[i] = (i >= int'(clo_r)) && (i <= int'(chi_r)) &&
                   !(wr_row_is_stn && (i == int'(stn_col_r)));
    end
  end
  assign wr_data = (valid_r[wr_row_r] ? rd_data_r : '0) | wr_mask;

  // Write stage comes in the cycle after the read of the same row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd.mark_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_step) begin
      wr_row_r <= row_r;
    end
  end

  // Row memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      mem[wr_row_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Valid bits: a row that was never written since a clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else if (wr_pend_r) begin
      valid_r[wr_row_r] <= 1'b1;
    end
  end

  // Result of the finished request.
  assign stored_bit = valid_r[ROW_AW'(rlo_r)] && rd_data_r[COL_AW'(clo_r)];
  always_comb begin
    cell_nxt = CELL_FREE;
    if (read_go) begin
      if (stn_at_read) begin
        cell_nxt = CELL_STATION;
      end else if (stored_bit) begin
        cell_nxt = CELL_OBSTACLE;
      end
    end
  end
  assign refused_nxt = mark_go && stn_hit;
  assign oor_nxt     = ((func_r == FUNC_MARK) && mark_oor) ||
                       ((func_r == FUNC_READ) && read_oor);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cell_r    <= cell_nxt;
      refused_r <= refused_nxt;
      oor_r     <= oor_nxt;
    end
  end

  assign cell_state      = cell_r;
  assign station_refused = refused_r;
  assign out_of_range    = oor_r;

  // A row write only follows a fill read of the cycle before.
  a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> $past(cmd.mark_step))
    else $error("row write without a preceding fill read");

  // The fill never steps past the last rectangle row.
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_step |-> (int'(row_r) <= int'(rhi_r)))
    else $error("fill row counter ran past the rectangle");

  // A fill write never sets the station cell.
  a_station_kept: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r && wr_row_is_stn && (int'(stn_col_r) < MAX_COLS)
      |-> !wr_mask[COL_AW'(stn_col_r)])
    else $error("fill write covered the station cell");

endmodule

### rtl/occupancy_grid_rect_fill.sv
// ----------------------------------------------------------------------------
// occupancy_grid_rect_fill: bitmap occupancy grid with a protected station
// Clears the grid, marks inclusive rectangles as obstacles and reads single
// cells, one request at a time, with one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ stream: in_tuser carries the operation code
//   (clear, mark, read) and in_tdata the rectangle corners. Each request
//   produces exactly one result on the out_ stream. The cfg_ port writes the
//   grid size and station position; the user must do so only while the block is idle, the block does not enforce it.
// Sequencing:
//   Clear and read pass the execute and done states to their result. A mark
//   that writes then reads and rewrites one memory row per cycle, drains
//   the last row write and then loads its result. The next request is
//   accepted in the cycle after the result is loaded.
// Reset:
//   rst_n is synchronous and active low. It clears the grid at once through
//   per-row valid bits, restores a 64 by 64 size and puts the station at
//   row 0, column 0.
// Stall:
//   The result waits in the output register while out_tready is low; the
//   block accepts and executes one new request and holds its result until
//   the register is free, accepting no further request until then.
// ----------------------------------------------------------------------------
module occupancy_grid_rect_fill
  import ogrf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write port.
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata,
  // Request stream.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // row_low, col_low, row_high, col_high
  input  logic [1:0]        in_tuser,   // func
  // Result stream.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata   // cell_state, station_refused, out_of_range
);

  ogrf_cmd_t         cmd;
  ogrf_stat_t        stat;
  logic [CELL_W-1:0] cell_state;
  logic              station_refused;
  logic              out_of_range;

  // Sequencer.
  ogrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Grid datapath.
  ogrf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .func            (in_tuser),
    .row_low         (in_tdata[5:0]),
    .col_low         (in_tdata[11:6]),
    .row_high        (in_tdata[17:12]),
    .col_high        (in_tdata[23:18]),
    .cell_state      (cell_state),
    .station_refused (station_refused),
    .out_of_range    (out_of_range),
    .cmd             (cmd),
    .stat            (stat)
  );

  // Result packing, padded to a whole byte.
  assign out_tdata = {4'b0000, out_of_range, station_refused, cell_state};

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for occupancy_grid_rect_fill
// Drives clear, mark and read requests on the request stream, keeps its own
// bitmap of the grid to predict each result, and checks every result
// field by field in arrival order. A short directed table walks the corner
// cases, then random phases under several grid sizes and station positions
// run with random idling on both streams but for one phase, and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
  import ogrf_pkg::*;
();

  // The fourth operation code, which the block must answer with all zeros.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int DIR_N      = 32;
  localparam int PHASE_N    = 9;
  localparam int PHASE_LEN  = 170;
  localparam int IDLE_PCT   = 28;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 80;

  // One result as the block reports it.
  typedef struct packed {
    logic [CELL_W-1:0] cell_st;
    logic              refused;
    logic              oor;
  } grid_result_t;

  localparam grid_result_t R_ZERO = {CELL_FREE, 1'b0, 1'b0};
  localparam grid_result_t R_FREE = {CELL_FREE, 1'b0, 1'b0};
  localparam grid_result_t R_OBS  = {CELL_OBSTACLE, 1'b0, 1'b0};
  localparam grid_result_t R_STN  = {CELL_STATION, 1'b0, 1'b0};
  localparam grid_result_t R_REF  = {CELL_FREE, 1'b1, 1'b0};
  localparam grid_result_t R_OOR  = {CELL_FREE, 1'b0, 1'b1};

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One row of the directed table: either a request or a register write.
  typedef struct {
    row_kind_t          kind;
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] rl;
    logic [COORD_W-1:0] cl;
    logic [COORD_W-1:0] rh;
    logic [COORD_W-1:0] ch;
    logic [CFG_IW-1:0]  reg_idx;
    logic [SIZE_W-1:0]  reg_val;
    bit                 typed;
    grid_result_t       res;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [SIZE_W-1:0] cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [23:0]       in_tdata;   // row_low, col_low, row_high, col_high
  logic [1:0]        in_tuser;   // func
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;  // cell_state, station_refused, out_of_range

  // Shadow state of the grid and its registers.
  logic [MAX_COLS-1:0] grid_bits [MAX_ROWS];
  logic [SIZE_W-1:0]   rows_sh;
  logic [SIZE_W-1:0]   cols_sh;
  logic [COORD_W-1:0]  stn_row_sh;
  logic [COORD_W-1:0]  stn_col_sh;

  grid_result_t results_due [$];
  stim_row_t    dir_tab [DIR_N];
  int           fail_count;
  bit           idle_on;
  bit           hold_out;

  occupancy_grid_rect_fill u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Usable sizes are capped at the storage limits.
  function automatic int rows_eff();
    return (rows_sh > MAX_ROWS) ? MAX_ROWS : int'(rows_sh);
  endfunction

  function automatic int cols_eff();
    return (cols_sh > MAX_COLS) ? MAX_COLS : int'(cols_sh);
  endfunction

  // Applies one request to the shadow grid and returns its result.
  function automatic grid_result_t grid_apply(logic [FUNC_W-1:0] fn,
                                              logic [COORD_W-1:0] rl,
                                              logic [COORD_W-1:0] cl,
                                              logic [COORD_W-1:0] rh,
                                              logic [COORD_W-1:0] ch);
    grid_result_t        res;
    int                  nr;
    int                  nc;
    logic [MAX_COLS-1:0] span;
    logic [MAX_COLS-1:0] rowm;
    res = R_ZERO;
    nr  = rows_eff();
    nc  = cols_eff();
    case (fn)
      FUNC_CLEAR: begin
        for (int r = 0; r < MAX_ROWS; r++) grid_bits[r] = '0;
      end
      FUNC_MARK: begin
        if (rl >= nr || rh >= nr || cl >= nc || ch >= nc) begin
          res.oor = 1'b1;
        end else if (rl <= rh && cl <= ch) begin
          span = ({MAX_COLS{1'b1}} << cl) & ({MAX_COLS{1'b1}} >> (6'd63 - ch));
          for (int r = rl; r <= rh; r++) begin
            rowm = span;
            // The station cell is never overwritten.
            if (r == stn_row_sh && stn_col_sh >= cl && stn_col_sh <= ch) begin
              rowm[stn_col_sh] = 1'b0;
              res.refused      = 1'b1;
            end
            grid_bits[r] = grid_bits[r] | rowm;
          end
        end
      end
      FUNC_READ: begin
        if (rl >= nr || cl >= nc) begin
          res.oor = 1'b1;
        end else if (rl == stn_row_sh && cl == stn_col_sh) begin
          res.cell_st = CELL_STATION;
        end else begin
          res.cell_st = grid_bits[rl][cl] ? CELL_OBSTACLE : CELL_FREE;
        end
      end
      default: res = R_ZERO;
    endcase
    return res;
  endfunction

  // A coordinate mostly inside the usable size, sometimes anywhere.
  function automatic logic [COORD_W-1:0] pick_coord(int lim);
    if (lim == 0 || $urandom_range(99) < 6) return COORD_W'($urandom_range(63));
    return COORD_W'($urandom_range(lim - 1, 0));
  endfunction

  // Offset from a base coordinate, held below the usable size unless the base already lies outside it.
  function automatic logic [COORD_W-1:0] grow_coord(logic [COORD_W-1:0] base,
                                                    int add, int lim);
    int v;
    v = int'(base) + add;
    if (lim == 0 || int'(base) >= lim) return base;
    if (v > lim - 1) v = lim - 1;
    return COORD_W'(v);
  endfunction

  // Offers one request, waits for its acceptance and records what it must
  // return.
  task automatic issue_request(input logic [FUNC_W-1:0] fn,
                               input logic [COORD_W-1:0] rl,
                               input logic [COORD_W-1:0] cl,
                               input logic [COORD_W-1:0] rh,
                               input logic [COORD_W-1:0] ch,
                               input bit typed, input grid_result_t typed_res);
    grid_result_t pred;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {ch, rh, cl, rl};
    do @(posedge clk); while (!in_tready);
    pred = grid_apply(fn, rl, cl, rh, ch);
    results_due.push_back(typed ? typed_res : pred);
  endtask

  // Writes one register once every outstanding result has come back.
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [SIZE_W-1:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROWS:    rows_sh    = val;
      CFG_COLS:    cols_sh    = val;
      CFG_STN_ROW: stn_row_sh = val[COORD_W-1:0];
      default:     stn_col_sh = val[COORD_W-1:0];
    endcase
  endtask

  // One random request, shaped mostly as in-range work, some of it at the station cell.
  task automatic random_request();
    int                 sel;
    int                 nr;
    int                 nc;
    logic [FUNC_W-1:0]  fn;
    logic [COORD_W-1:0] rl;
    logic [COORD_W-1:0] cl;
    logic [COORD_W-1:0] rh;
    logic [COORD_W-1:0] ch;
    nr  = rows_eff();
    nc  = cols_eff();
    sel = $urandom_range(99);
    rl  = COORD_W'($urandom_range(63));
    cl  = COORD_W'($urandom_range(63));
    rh  = COORD_W'($urandom_range(63));
    ch  = COORD_W'($urandom_range(63));
    if (sel < 3) begin
      fn = FUNC_CLEAR;
    end else if (sel < 6) begin
      fn = FUNC_UNUSED;
    end else if (sel < 42) begin
      fn  = FUNC_MARK;
      sel = $urandom_range(99);
      if (sel < 3 && nr > 0 && nc > 0) begin
        // Whole usable grid.
        rl = '0;
        cl = '0;
        rh = COORD_W'(nr - 1);
        ch = COORD_W'(nc - 1);
      end else if (sel < 18) begin
        // A small rectangle around the station cell.
        rl = (stn_row_sh > 1) ? stn_row_sh - COORD_W'($urandom_range(2)) : stn_row_sh;
        cl = (stn_col_sh > 1) ? stn_col_sh - COORD_W'($urandom_range(2)) : stn_col_sh;
        rh = grow_coord(rl, $urandom_range(3), nr);
        ch = grow_coord(cl, $urandom_range(3), nc);
      end else if (sel < 33) begin
        // Arbitrary corners, often an empty or out-of-range rectangle.
        rl = pick_coord(nr);
        cl = pick_coord(nc);
        rh = pick_coord(nr);
        ch = pick_coord(nc);
      end else begin
        rl = pick_coord(nr);
        cl = pick_coord(nc);
        rh = grow_coord(rl, $urandom_range(7), nr);
        ch = grow_coord(cl, $urandom_range(15), nc);
      end
    end else begin
      fn = FUNC_READ;
      if ($urandom_range(99) < 15) begin
        rl = stn_row_sh;
        cl = stn_col_sh;
      end else begin
        rl = pick_coord(nr);
        cl = pick_coord(nc);
      end
    end
    issue_request(fn, rl, cl, rh, ch, 1'b0, R_ZERO);
  endtask

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    grid_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (out_tdata[1:0] !== want.cell_st) begin
          $display("%0t: cell_state expected %0d actual %0d",
                   $time, want.cell_st, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tdata[2] !== want.refused) begin
          $display("%0t: station_refused expected %0d actual %0d",
                   $time, want.refused, out_tdata[2]);
          fail_count++;
        end
        if (out_tdata[3] !== want.oor) begin
          $display("%0t: out_of_range expected %0d actual %0d",
                   $time, want.oor, out_tdata[3]);
          fail_count++;
        end
      end
    end
  end

  // Result receiver: random back-pressure while idling is on, else always ready, or one long hold when asked.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_out = 1'b0;
      end else if (idle_on) begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Reset, directed table, random phases and the final verdict.
  initial begin
    int rv;
    int cv;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    fail_count = 0;
    idle_on    = 1'b1;
    hold_out   = 1'b0;
    rows_sh    = 7'd64;
    cols_sh    = 7'd64;
    stn_row_sh = '0;
    stn_col_sh = '0;
    for (int r = 0; r < MAX_ROWS; r++) grid_bits[r] = '0;

    dir_tab = '{
      '{ROW_REQ, FUNC_READ,    0,  0,  0,  0, CFG_ROWS,    7'd0,   1'b1, R_STN},
      '{ROW_REQ, FUNC_READ,   63, 63,  0,  0, CFG_ROWS,    7'd0,   1'b1, R_FREE},
      '{ROW_REQ, FUNC_MARK,    0,  0, 63, 63, CFG_ROWS,    7'd0,   1'b1, R_REF},
      '{ROW_REQ, FUNC_READ,   63, 63,  0,  0, CFG_ROWS,    7'd0,   1'b1, R_OBS},
      '{ROW_REQ, FUNC_READ,    0,  0,  0,  0, CFG_ROWS,    7'd0,   1'b1, R_STN},
      '{ROW_REQ, FUNC_READ,    0,  1,  0,  0, CFG_ROWS,    7'd0,   1'b0, R_ZERO},
      '{ROW_REQ, FUNC_CLEAR,  63, 63, 63, 63, CFG_ROWS,    7'd0,   1'b1, R_ZERO},
      '{ROW_REQ, FUNC_READ,   31, 17,  0,  0, CFG_ROWS,    7'd0,   1'b1, R_FREE},
      '{ROW_REQ, FUNC_MARK,   10,  3,  2,  7, CFG_ROWS,    7'd0,   1'b1, R_ZERO},
      '{ROW_REQ, FUNC_MARK,    3, 10,  7,  2, CFG_ROWS,    7'd0,   1'b1, R_ZERO},
      '{ROW_REQ, FUNC_MARK,    5,  5,  5,  5, CFG_ROWS,    7'd0,   1'b0, R_ZERO},
      '{ROW_REQ, FUNC_READ,    5,  5,  0,  0, CFG_ROWS,    7'd0,   1'b0, R_ZERO},
      '{ROW_REQ, FUNC_UNUSED, 63, 63, 63, 63, CFG_ROWS,    7'd0,   1'b1, R_ZERO},
      '{ROW_CFG, FUNC_CLEAR,   0,  0,  0,  0, CFG_ROWS,    7'd10,  1'b0, R_ZERO},
      '{ROW_CFG, FUNC_CLEAR,   0,  0,  0,  0, CFG_COLS,    7'd20,  1'b0, R_ZERO},
      '{ROW_CFG, FUNC_CLEAR,   0,  0,  0,  0, CFG_STN_ROW, 7'd5,   1'b0, R_ZERO},
      '{ROW_CFG, FUNC_CLEAR,   0,  0,  0,  0, CFG_STN_COL, 7'd5,   1'b0, R_ZERO},
      '{ROW_REQ, FUNC_READ,    5,  5,  0,  0, CFG_ROWS,    7'd0,   1'b1, R_STN},
      '{ROW_REQ, FUNC_READ,   10,  0,  0,  0, CFG_ROWS,    7'd0,   1'b1, R_OOR},
      '{ROW_REQ, FUNC_READ,    0, 20,  0,  0, CFG_ROWS,    7'd0,   1'b1, R_OOR},
      '{ROW_REQ, FUNC_MARK,    0,  0,  9, 19, CFG_ROWS,    7'd0,   1'b1, R_REF},
      '{ROW_REQ, FUNC_MARK,    9,  0, 10,  0, CFG_ROWS,    7'd0,   1'b1, R_OOR},
      '{ROW_REQ, FUNC_MARK,   12,  0,  3,  0, CFG_ROWS,    7'd0,   1'b1, R_OOR},
      '{ROW_REQ, FUNC_MARK,    0, 21,  0,  0, CFG_ROWS,    7'd0,   1'b1, R_OOR},
      '{ROW_CFG, FUNC_CLEAR,   0,  0,  0,  0, CFG_STN_ROW, 7'd64,  1'b0, R_ZERO},
      '{ROW_CFG, FUNC_CLEAR,   0,  0,  0,  0, CFG_STN_COL, 7'd0,   1'b0, R_ZERO},
      '{ROW_REQ, FUNC_READ,    5,  5,  0,  0, CFG_ROWS,    7'd0,   1'b0, R_ZERO},
      '{ROW_CFG, FUNC_CLEAR,   0,  0,  0,  0, CFG_ROWS,    7'd0,   1'b0, R_ZERO},
      '{ROW_REQ, FUNC_READ,    0,  0,  0,  0, CFG_ROWS,    7'd0,   1'b1, R_OOR},
      '{ROW_CFG, FUNC_CLEAR,   0,  0,  0,  0, CFG_ROWS,    7'd127, 1'b0, R_ZERO},
      '{ROW_CFG, FUNC_CLEAR,   0,  0,  0,  0, CFG_COLS,    7'd127, 1'b0, R_ZERO},
      '{ROW_REQ, FUNC_READ,   63, 63,  0,  0, CFG_ROWS,    7'd0,   1'b0, R_ZERO}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        issue_request(dir_tab[i].func, dir_tab[i].rl, dir_tab[i].cl,
                      dir_tab[i].rh, dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Random phases, each under its own size and station position. The grid
    // is not cleared between phases, so shrunken sizes hide stored bits.
    for (int ph = 0; ph < PHASE_N; ph++) begin
      case (ph)
        0: begin rv = 64; cv = 64; end
        1: begin rv = 1;  cv = 1;  end
        2: begin rv = 64; cv = 1;  end
        3: begin rv = 1;  cv = 64; end
        4: begin rv = 127; cv = 127; end
        default: begin
          rv = ($urandom_range(9) == 0) ? $urandom_range(127, 65) : $urandom_range(64, 1);
          cv = ($urandom_range(9) == 0) ? $urandom_range(127, 65) : $urandom_range(64, 1);
        end
      endcase
      write_reg(CFG_ROWS, SIZE_W'(rv));
      write_reg(CFG_COLS, SIZE_W'(cv));
      write_reg(CFG_STN_ROW, (ph == 1 || ph == 3) ? 7'd0 : SIZE_W'($urandom_range(127)));
      write_reg(CFG_STN_COL, (ph == 1 || ph == 2) ? 7'd0 : SIZE_W'($urandom_range(127)));
      // A stretch with no idling on either stream.
      idle_on = (ph != 4);
      for (int k = 0; k < PHASE_LEN; k++) begin
        // Hold results back for a long time so the input stalls as well.
        if (ph == 0 && k == 60) hold_out = 1'b1;
        random_request();
      end
    end
    idle_on = 1'b1;

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ogrf_pkg.sv
rtl/ogrf_ctrl.sv
rtl/ogrf_dp.sv
rtl/occupancy_grid_rect_fill.sv
tb/tb.sv
